// ----- rtl/pdb_pkg.sv -----
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types and constants for the drive balance PID controller.
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int GAIN_W     = 16;
  localparam int ZONE_W     = 10;
  localparam int LIMIT_W    = 7;
  localparam int DRIVE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ZONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 3'd5;

  // reset values
  localparam logic [GAIN_W-1:0]  RST_GAIN_P        = 16'd4096;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I        = 16'd164;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D        = 16'd0;
  localparam logic [ZONE_W-1:0]  RST_INTEGRAL_ZONE = 10'd40;
  localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT   = 7'd127;
  localparam logic               RST_INVERT_OUTPUT = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [ZONE_W-1:0]  integral_zone;
    logic [LIMIT_W-1:0] drive_limit;
    logic               invert_output;
  } cfg_t;

endpackage

// ----- rtl/pdb_err.sv -----
// ----------------------------------------------------------------------------
// pdb_err
// Error stage: error, integral zone and saturation, derivative. Holds the
// controller history, which doubles as the operand register for the next stage.
// ----------------------------------------------------------------------------
module pdb_err #(
  parameter int COUNT_BITS    = 24,
  parameter int INTEGRAL_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              enable_i,
  input  logic signed [COUNT_BITS-1:0]      left_i,
  input  logic signed [COUNT_BITS-1:0]      right_i,
  input  logic [pdb_pkg::ZONE_W-1:0]        zone_i,
  output logic signed [COUNT_BITS:0]        err_o,
  output logic signed [COUNT_BITS+1:0]      deriv_o,
  output logic signed [INTEGRAL_BITS-1:0]   integ_o
);
  import pdb_pkg::*;

  localparam int EW = COUNT_BITS + 1;
  localparam int DW = COUNT_BITS + 2;
  localparam int IB = INTEGRAL_BITS;
  localparam int SW = ((IB > EW) ? IB : EW) + 1;
  localparam logic signed [SW-1:0] IMAX = {{(SW-IB+1){1'b0}}, {(IB-1){1'b1}}};
  localparam logic signed [SW-1:0] IMIN = {{(SW-IB+1){1'b1}}, {(IB-1){1'b0}}};

  logic signed [EW-1:0] prev_q, prev_d;
  logic signed [IB-1:0] integ_q, integ_d;
  logic signed [DW-1:0] deriv_q;
  logic signed [EW-1:0] err_c;
  logic        [EW-1:0] mag_c;
  logic                 in_zone_c;
  logic signed [SW-1:0] acc_c;
  logic signed [IB-1:0] acc_sat_c;

  assign err_c     = EW'(left_i) - EW'(right_i);
  assign mag_c     = err_c[EW-1] ? EW'(-err_c) : EW'(err_c);
  assign in_zone_c = mag_c < EW'(zone_i);
  assign acc_c     = SW'(integ_q) + SW'(err_c);

  always_comb begin
    if (acc_c > IMAX) begin
      acc_sat_c = IB'(IMAX);
    end else if (acc_c < IMIN) begin
      acc_sat_c = IB'(IMIN);
    end else begin
      acc_sat_c = IB'(acc_c);
    end
  end

  always_comb begin
    prev_d  = prev_q;
    integ_d = integ_q;
    if (step_i) begin
      if (enable_i) begin
        prev_d  = err_c;
        integ_d = in_zone_c ? acc_sat_c : '0;
      end else begin
        prev_d  = '0;
        integ_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else begin
      prev_q  <= prev_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && enable_i) begin
      deriv_q <= DW'(err_c) - DW'(prev_q);
    end
  end

  assign err_o   = prev_q;
  assign deriv_o = deriv_q;
  assign integ_o = integ_q;

endmodule

// ----- rtl/pdb_mix.sv -----
// ----------------------------------------------------------------------------
// pdb_mix
// Output stage: weighted PID sum, truncation toward zero, clamp, optional
// negation, registered drive.
// ----------------------------------------------------------------------------
module pdb_mix #(
  parameter int COUNT_BITS     = 24,
  parameter int GAIN_FRAC_BITS = 12,
  parameter int INTEGRAL_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  pdb_pkg::cfg_t                     cfg_i,
  input  logic signed [COUNT_BITS:0]        err_i,
  input  logic signed [COUNT_BITS+1:0]      deriv_i,
  input  logic signed [INTEGRAL_BITS-1:0]   integ_i,
  output logic signed [pdb_pkg::DRIVE_W-1:0] drive_o
);
  import pdb_pkg::*;

  localparam int EW   = COUNT_BITS + 1;
  localparam int DW   = COUNT_BITS + 2;
  localparam int IB   = INTEGRAL_BITS;
  localparam int GW   = GAIN_W + 1;
  localparam int MW   = (DW > IB) ? DW : IB;
  localparam int SUMW = MW + GW + 2;

  logic signed [GW-1:0]      gp_s, gi_s, gd_s;
  logic signed [EW+GW-1:0]   prod_p;
  logic signed [IB+GW-1:0]   prod_i;
  logic signed [DW+GW-1:0]   prod_d;
  logic signed [SUMW-1:0]    sum_c, quo_c, quo_adj_c, lim_c, nlim_c, clamp_c;
  logic                      round_up_c;
  logic signed [DRIVE_W-1:0] drv_c, drive_q;

  assign gp_s = $signed({1'b0, cfg_i.gain_p});
  assign gi_s = $signed({1'b0, cfg_i.gain_i});
  assign gd_s = $signed({1'b0, cfg_i.gain_d});

  assign prod_p = gp_s * err_i;
  assign prod_i = gi_s * integ_i;
  assign prod_d = gd_s * deriv_i;

  assign sum_c = SUMW'(prod_p) + SUMW'(prod_i) + SUMW'(prod_d);

  // floor shift, then bump negatives with a fraction back toward zero
  assign quo_c      = sum_c >>> GAIN_FRAC_BITS;
  assign round_up_c = sum_c[SUMW-1] && (|sum_c[GAIN_FRAC_BITS-1:0]);
  assign quo_adj_c  = quo_c + $signed({{(SUMW-1){1'b0}}, round_up_c});

  assign lim_c  = $signed({{(SUMW-LIMIT_W){1'b0}}, cfg_i.drive_limit});
  assign nlim_c = -lim_c;

  always_comb begin
    if (quo_adj_c > lim_c) begin
      clamp_c = lim_c;
    end else if (quo_adj_c < nlim_c) begin
      clamp_c = nlim_c;
    end else begin
      clamp_c = quo_adj_c;
    end
  end

  assign drv_c = cfg_i.invert_output ? DRIVE_W'(-clamp_c) : DRIVE_W'(clamp_c);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= drv_c;
    end
  end

  assign drive_o = drive_q;

endmodule

// ----- rtl/pid_drive_balance_controller.sv -----
// ----------------------------------------------------------------------------
// pid_drive_balance_controller
// PID wheel balance controller with integral zone, saturating integral and
// clamped, optionally inverted drive output.
// ----------------------------------------------------------------------------
// Pipeline: the input reg loads on the beat, then the error stage, then the
//   output reg. Throughput: one beat per cycle while the output is not stalled,
//   set by the error/integral update feeding back into its own history registers.
// Disabled ticks clear the history and produce no output beat.
// Reset: async active low; clears valids, history and loads register defaults.
module pid_drive_balance_controller #(
  parameter int COUNT_BITS     = 24,
  parameter int GAIN_FRAC_BITS = 12,
  parameter int INTEGRAL_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pdb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                enable_i,
  input  logic signed [COUNT_BITS-1:0]        left_count_i,
  input  logic signed [COUNT_BITS-1:0]        right_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pdb_pkg::DRIVE_W-1:0]  drive_o
);
  import pdb_pkg::*;

  cfg_t cfg_q, cfg_d;

  logic                         s0_v_q, s0_v_d;
  logic                         s0_en_q;
  logic signed [COUNT_BITS-1:0] s0_left_q, s0_right_q;
  logic                         s1_v_q, s1_v_d;
  logic                         out_v_q, out_v_d;
  logic                         in_ld, s0_mv, s1_free, out_ld;

  logic signed [COUNT_BITS:0]      err;
  logic signed [COUNT_BITS+1:0]    deriv;
  logic signed [INTEGRAL_BITS-1:0] integ;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_P:        cfg_d.gain_p        = cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:        cfg_d.gain_i        = cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:        cfg_d.gain_d        = cfg_data_i[GAIN_W-1:0];
        REG_INTEGRAL_ZONE: cfg_d.integral_zone = cfg_data_i[ZONE_W-1:0];
        REG_DRIVE_LIMIT:   cfg_d.drive_limit   = cfg_data_i[LIMIT_W-1:0];
        REG_INVERT_OUTPUT: cfg_d.invert_output = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= RST_GAIN_P;
      cfg_q.gain_i        <= RST_GAIN_I;
      cfg_q.gain_d        <= RST_GAIN_D;
      cfg_q.integral_zone <= RST_INTEGRAL_ZONE;
      cfg_q.drive_limit   <= RST_DRIVE_LIMIT;
      cfg_q.invert_output <= RST_INVERT_OUTPUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline flow control
  assign out_ld     = s1_v_q && (!out_v_q || out_ready_i);
  assign s1_free    = !s1_v_q || out_ld;
  assign s0_mv      = s0_v_q && s1_free;
  assign in_ready_o = !s0_v_q || s1_free;
  assign in_ld      = in_valid_i && in_ready_o;

  always_comb begin
    s0_v_d = s0_v_q;
    if (in_ld) begin
      s0_v_d = 1'b1;
    end else if (s0_mv) begin
      s0_v_d = 1'b0;
    end

    s1_v_d = s1_v_q;
    if (s0_mv) begin
      s1_v_d = s0_en_q;  // disabled ticks only touch history
    end else if (out_ld) begin
      s1_v_d = 1'b0;
    end

    out_v_d = out_v_q;
    if (out_ld) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s0_v_q  <= s0_v_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ld) begin
      s0_en_q    <= enable_i;
      s0_left_q  <= left_count_i;
      s0_right_q <= right_count_i;
    end
  end

  pdb_err #(
    .COUNT_BITS    (COUNT_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s0_mv),
    .enable_i (s0_en_q),
    .left_i   (s0_left_q),
    .right_i  (s0_right_q),
    .zone_i   (cfg_q.integral_zone),
    .err_o    (err),
    .deriv_o  (deriv),
    .integ_o  (integ)
  );

  pdb_mix #(
    .COUNT_BITS     (COUNT_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .INTEGRAL_BITS  (INTEGRAL_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .load_i  (out_ld),
    .cfg_i   (cfg_q),
    .err_i   (err),
    .deriv_i (deriv),
    .integ_i (integ),
    .drive_o (drive_o)
  );

  assign out_valid_o = out_v_q;

endmodule
